@@ src/tks_pkg.sv @@
// Shared types and defaults for the top-k index selector.
package tks_pkg;

    // Default build sizes
    localparam int unsigned MAX_K_DEFAULT         = 16;
    localparam int unsigned POSITION_BITS_DEFAULT = 16;
    localparam int unsigned VALUE_BITS_DEFAULT    = 32;

    // Width of the k register and its reset value
    localparam int unsigned TOP_COUNT_BITS  = 5;
    localparam logic [TOP_COUNT_BITS-1:0] TOP_COUNT_RESET = TOP_COUNT_BITS'(16);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic insert;     // rank the accepted beat into the list
        logic shift_out;  // drop the head entry, move the list up
        logic finish;     // clear count, position and overflow for the next stream
    } tks_cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } tks_state_t;

endpackage

@@ src/tks_ctrl.sv @@
// Controller: collects a stream, then plays out the ranked list one beat at a time.
module tks_ctrl #(
    parameter int unsigned MAX_K = tks_pkg::MAX_K_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         end_of_set,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         final_result,
    input  logic [$clog2(MAX_K+1)-1:0]   emit_count,
    output tks_pkg::tks_cmd_t            cmd
);

    localparam int unsigned CW = $clog2(MAX_K + 1);

    tks_pkg::tks_state_t state_reg, state_next;
    logic [CW-1:0]       remain_reg, remain_next;
    logic                in_fire, out_fire, last_beat;

    assign in_ready     = (state_reg == tks_pkg::ST_COLLECT);
    assign out_valid    = (state_reg == tks_pkg::ST_EMIT);
    assign in_fire      = in_valid && in_ready;
    assign out_fire     = out_valid && out_ready;
    assign last_beat    = (remain_reg == CW'(1));
    assign final_result = last_beat;

    // Decode commands and next state
    always_comb
    begin
        state_next    = state_reg;
        remain_next   = remain_reg;
        cmd.insert    = 1'b0;
        cmd.shift_out = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            tks_pkg::ST_COLLECT:
            begin
                if (in_fire)
                begin
                    cmd.insert = 1'b1;
                    if (end_of_set)
                    begin
                        remain_next = emit_count;
                        state_next  = tks_pkg::ST_EMIT;
                    end
                end
            end
            tks_pkg::ST_EMIT:
            begin
                if (out_fire)
                begin
                    cmd.shift_out = 1'b1;
                    remain_next   = remain_reg - CW'(1);
                    if (last_beat)
                    begin
                        cmd.finish = 1'b1;
                        state_next = tks_pkg::ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = tks_pkg::ST_COLLECT;
            end
        endcase
    end

    // Hold state and beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tks_pkg::ST_COLLECT;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

endmodule

@@ src/tks_datapath.sv @@
// Datapath: sorted register chain with parallel compare-and-shift insertion.
module tks_datapath #(
    parameter int unsigned MAX_K         = tks_pkg::MAX_K_DEFAULT,
    parameter int unsigned POSITION_BITS = tks_pkg::POSITION_BITS_DEFAULT,
    parameter int unsigned VALUE_BITS    = tks_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tks_pkg::TOP_COUNT_BITS-1:0]   cfg_wdata,
    input  logic signed [VALUE_BITS-1:0]         sample_value,
    input  tks_pkg::tks_cmd_t                    cmd,
    output logic [$clog2(MAX_K+1)-1:0]           emit_count,
    output logic [POSITION_BITS-1:0]             position,
    output logic signed [VALUE_BITS-1:0]         ranked_value,
    output logic                                 position_overflow
);

    localparam int unsigned CW = $clog2(MAX_K + 1);

    logic signed [VALUE_BITS-1:0]         val_reg [MAX_K];
    logic [POSITION_BITS-1:0]             pos_reg [MAX_K];
    logic [MAX_K-1:0]                     take_new;
    logic [CW-1:0]                        count_reg, count_next, count_after;
    logic [POSITION_BITS:0]               next_pos_reg, next_pos_next;
    logic                                 ovf_reg, ovf_next;
    logic [tks_pkg::TOP_COUNT_BITS-1:0]   top_count_reg;
    logic [CW-1:0]                        k_eff;
    logic                                 pos_sat;
    logic [POSITION_BITS-1:0]             new_pos;

    // Saturate the stream position
    assign pos_sat = next_pos_reg[POSITION_BITS];
    assign new_pos = pos_sat ? {POSITION_BITS{1'b1}} : next_pos_reg[POSITION_BITS-1:0];

    // Flag each slot the new beat outranks; ties keep the earlier entry ahead
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            take_new[i] = (CW'(i) >= count_reg) || (sample_value > val_reg[i]);
        end
    end

    // Move entries down behind the insertion point, or up when a beat leaves
    for (genvar g = 0; g < MAX_K; g++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (cmd.shift_out)
            begin
                if (g < MAX_K - 1)
                begin
                    val_reg[g] <= val_reg[(g + 1) % MAX_K];
                    pos_reg[g] <= pos_reg[(g + 1) % MAX_K];
                end
            end
            else if (cmd.insert)
            begin
                if (g > 0 && take_new[(g + MAX_K - 1) % MAX_K])
                begin
                    val_reg[g] <= val_reg[(g + MAX_K - 1) % MAX_K];
                    pos_reg[g] <= pos_reg[(g + MAX_K - 1) % MAX_K];
                end
                else if (take_new[g])
                begin
                    val_reg[g] <= sample_value;
                    pos_reg[g] <= new_pos;
                end
            end
        end
    end

    // Clamp k into 1..MAX_K and work out how many beats the stream yields
    always_comb
    begin
        if (top_count_reg == '0)
            k_eff = CW'(1);
        else if (int'(top_count_reg) > MAX_K)
            k_eff = CW'(MAX_K);
        else
            k_eff = CW'(top_count_reg);
        count_after = (int'(count_reg) < MAX_K) ? count_reg + CW'(1) : count_reg;
        emit_count  = (count_after < k_eff) ? count_after : k_eff;
    end

    // Advance count, position and overflow
    always_comb
    begin
        count_next    = count_reg;
        next_pos_next = next_pos_reg;
        ovf_next      = ovf_reg;
        if (cmd.finish)
        begin
            count_next    = '0;
            next_pos_next = '0;
            ovf_next      = 1'b0;
        end
        else if (cmd.insert)
        begin
            count_next = count_after;
            if (pos_sat)
                ovf_next = 1'b1;
            else
                next_pos_next = next_pos_reg + (POSITION_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            next_pos_reg  <= '0;
            ovf_reg       <= 1'b0;
            top_count_reg <= tks_pkg::TOP_COUNT_RESET;
        end
        else
        begin
            count_reg    <= count_next;
            next_pos_reg <= next_pos_next;
            ovf_reg      <= ovf_next;
            if (cfg_we)
                top_count_reg <= cfg_wdata;
        end
    end

    // Head of the list drives the result beat
    assign position          = pos_reg[0];
    assign ranked_value      = val_reg[0];
    assign position_overflow = ovf_reg;

endmodule

@@ src/top_k_index_selector.sv @@
// Top level of the streaming top-k index selector.
//
// Input channel (in_valid/in_ready): one beat per stream item, sample_value
// plus end_of_set marking the last item. Items are numbered from zero; the
// position saturates at its top value and position_overflow is then raised.
// Each beat is ranked into a sorted register chain as it is accepted, so a stream
// is taken at one item per clock.
// Output channel (out_valid/out_ready): after the marked item, the best
// min(k, items seen) entries, k clamped into 1..MAX_K, leave in descending
// value order, earlier position first among equal values, one beat per
// cycle unless stalled; final_result marks the last. The first result is
// offered the cycle after the marked item. No input is taken while results
// play out; a stalled receiver simply holds the current beat, and the next
// stream starts the cycle after the last result is taken.
// Config: cfg_we writes k (cfg_wdata) at the clock edge; write only while idle.
// Reset clears the entry count, position and overflow flag and sets k to 16.
module top_k_index_selector #(
    parameter int unsigned MAX_K         = tks_pkg::MAX_K_DEFAULT,
    parameter int unsigned POSITION_BITS = tks_pkg::POSITION_BITS_DEFAULT,
    parameter int unsigned VALUE_BITS    = tks_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tks_pkg::TOP_COUNT_BITS-1:0]   cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [VALUE_BITS-1:0]         sample_value,
    input  logic                                 end_of_set,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [POSITION_BITS-1:0]             position,
    output logic signed [VALUE_BITS-1:0]         ranked_value,
    output logic                                 final_result,
    output logic                                 position_overflow
);

    tks_pkg::tks_cmd_t             cmd;
    logic [$clog2(MAX_K+1)-1:0]    emit_count;

    // Sequence collection and playout
    tks_ctrl #(
        .MAX_K (MAX_K)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .end_of_set   (end_of_set),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .final_result (final_result),
        .emit_count   (emit_count),
        .cmd          (cmd)
    );

    // Hold and rank the list
    tks_datapath #(
        .MAX_K         (MAX_K),
        .POSITION_BITS (POSITION_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .sample_value      (sample_value),
        .cmd               (cmd),
        .emit_count        (emit_count),
        .position          (position),
        .ranked_value      (ranked_value),
        .position_overflow (position_overflow)
    );

endmodule
